>>> hw/rtl/rpnsa_pkg.sv
// Package: shared types, constants and codes for the RPN stack arithmetic unit.
package rpnsa_pkg;

	localparam int StackDepth = 64;
	localparam int FracBits   = 16;
	localparam int AddrW      = $clog2(StackDepth);
	localparam int CountW     = $clog2(StackDepth + 1);
	localparam int DepthW     = 7;

	localparam logic [63:0] PosMax  = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] NegMax  = 64'h8000_0000_0000_0000;

	typedef enum logic [2:0] {
		ST_OK   = 3'd0,
		ST_FEW  = 3'd1,
		ST_FULL = 3'd2,
		ST_DIVZ = 3'd3,
		ST_SAT  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic {
		REQ_PUSH = 1'b0,
		REQ_OPER = 1'b1
	} req_t;

	typedef struct packed {
		logic               req_type;
		logic signed [63:0] push_value;
		logic [1:0]         op_code;
		logic               reduce_all;
	} req_item_t;

	typedef struct packed {
		logic signed [63:0] top_value;
		logic [2:0]         status;
		logic [6:0]         depth_after;
	} rsp_item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PUSH,
		S_RD_A,
		S_RD_B,
		S_OPND,
		S_CALC,
		S_WR,
		S_RD_TOP,
		S_TOP,
		S_DONE
	} ctl_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load_req;
		logic wr_push;
		logic rd_a;
		logic rd_b;
		logic rd_top;
		logic cap_a;
		logic cap_b;
		logic calc_start;
		logic wr_result;
		logic cap_top;
		logic set_few;
		logic set_full;
		logic set_divz;
		logic emit;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_oper;
		logic reduce;
		logic full;
		logic few;
		logic empty;
		logic divz;
		logic calc_done;
		logic more;
	} dp_sts_t;

endpackage

>>> hw/rtl/rpn_stack_arithmetic_unit.sv
// Top level: RPN stack arithmetic unit.
// Takes one request when start is high and busy low; returns exactly one result, shown on
// result with done high for one cycle, which the receiver must take then. The divide is
// bit-serial, one quotient bit per cycle over 128 bits, followed by a finish state. busy
// drops in the cycle that done is high, so the next transfer can overlap the result. Stack
// is a single-port RAM of 64 entries.
module rpn_stack_arithmetic_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  rpnsa_pkg::req_item_t request,
	output logic                 busy,
	output logic                 done,
	output rpnsa_pkg::rsp_item_t result
);
	import rpnsa_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	rpnsa_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.cmd   (cmd),
		.sts   (sts)
	);

	rpnsa_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (request),
		.cmd      (cmd),
		.sts      (sts),
		.rsp      (result),
		.rsp_valid(done)
	);
endmodule

>>> hw/rtl/rpnsa_ram.sv
// Generic single-port RAM with registered read.
module rpnsa_ram #(
	parameter int Width = 64,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

>>> hw/rtl/rpnsa_alu.sv
// Multicycle arithmetic unit: saturating add/sub, 32x32 partial-product multiply, radix-2 divide.
module rpnsa_alu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [1:0]  op,
	input  logic [63:0] b_in,
	input  logic [63:0] a_in,
	output logic        done,
	output logic [63:0] result,
	output logic        sat
);
	import rpnsa_pkg::*;

	typedef enum logic [2:0] {A_IDLE, A_MUL, A_DIV, A_FIN} alu_state_t;

	alu_state_t   state_q;
	logic         neg_q;
	logic [63:0]  x_q, y_q;
	logic [127:0] acc_q;     // multiply product / divide quotient
	logic [127:0] num_q;     // divide numerator shifting out
	logic [63:0]  rem_q;
	logic [1:0]   pp_q;
	logic [6:0]   cnt_q;
	logic [63:0]  res_q;
	logic         sat_q;
	logic         fin_q;

	logic [63:0]  mag_b, mag_a;
	logic [64:0]  rem_sh;
	logic [64:0]  rem_sub;
	logic [31:0]  px, py;
	logic [63:0]  pp;
	logic [127:0] pp_ext;
	logic [127:0] shifted;
	logic [63:0]  sum, diff;
	logic         add_ovf, sub_ovf;
	logic [63:0]  limit;

	assign mag_b = b_in[63] ? (64'd0 - b_in) : b_in;
	assign mag_a = a_in[63] ? (64'd0 - a_in) : a_in;
	assign sum   = b_in + a_in;
	assign diff  = b_in - a_in;
	assign add_ovf = (b_in[63] == a_in[63]) && (sum[63] != b_in[63]);
	assign sub_ovf = (b_in[63] != a_in[63]) && (diff[63] != b_in[63]);

	assign px = pp_q[0] ? x_q[63:32] : x_q[31:0];
	assign py = pp_q[1] ? y_q[63:32] : y_q[31:0];
	assign pp = px * py;
	// shift is 32 per high half taken: 0, 32 or 64
	always_comb begin
		pp_ext = {64'd0, pp};
		pp_ext = pp_ext << {pp_q[0] & pp_q[1], pp_q[0] ^ pp_q[1], 5'd0};
	end

	assign rem_sh  = {rem_q, num_q[127]};
	assign rem_sub = rem_sh - {1'b0, y_q};

	assign shifted = acc_q >> FracBits;
	assign limit   = neg_q ? NegMax : PosMax;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			fin_q   <= 1'b0;
		end else begin
			fin_q <= 1'b0;
			unique case (state_q)
				A_IDLE: begin
					if (start) begin
						unique case (op)
							OP_ADD, OP_SUB: begin
								fin_q <= 1'b1;
							end
							OP_MUL: state_q <= A_MUL;
							default: state_q <= A_DIV;
						endcase
					end
				end
				A_MUL: if (pp_q == 2'd3) state_q <= A_FIN;
				A_DIV: if (cnt_q == 7'd127) state_q <= A_FIN;
				A_FIN: begin
					state_q <= A_IDLE;
					fin_q   <= 1'b1;
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			A_IDLE: begin
				if (start) begin
					neg_q <= b_in[63] ^ a_in[63];
					x_q   <= mag_b;
					y_q   <= mag_a;
					acc_q <= '0;
					num_q <= {mag_b, 64'd0} >> (64 - FracBits);
					rem_q <= '0;
					pp_q  <= '0;
					cnt_q <= '0;
					unique case (op)
						OP_ADD: begin
							res_q <= add_ovf ? (b_in[63] ? NegMax : PosMax) : sum;
							sat_q <= add_ovf;
						end
						OP_SUB: begin
							res_q <= sub_ovf ? (b_in[63] ? NegMax : PosMax) : diff;
							sat_q <= sub_ovf;
						end
						default: ;
					endcase
				end
			end
			A_MUL: begin
				acc_q <= acc_q + pp_ext;
				pp_q  <= pp_q + 2'd1;
			end
			A_DIV: begin
				num_q <= num_q << 1;
				cnt_q <= cnt_q + 7'd1;
				if (!rem_sub[64]) begin
					rem_q <= rem_sub[63:0];
					acc_q <= {acc_q[126:0], 1'b1};
				end else begin
					rem_q <= rem_sh[63:0];
					acc_q <= {acc_q[126:0], 1'b0};
				end
			end
			A_FIN: begin
				// multiply drops fraction bits here; divide already scaled
				begin : fin_blk
					logic [127:0] m;
					m = (op == OP_MUL) ? shifted : acc_q;
					if (m[127:64] != 64'd0 || m[63:0] > limit) begin
						res_q <= neg_q ? NegMax : PosMax;
						sat_q <= 1'b1;
					end else begin
						res_q <= neg_q ? (64'd0 - m[63:0]) : m[63:0];
						sat_q <= 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

	assign done   = fin_q;
	assign result = res_q;
	assign sat    = sat_q;
endmodule

>>> hw/rtl/rpnsa_datapath.sv
// Datapath: stack RAM, count, operand registers, ALU and result register.
module rpnsa_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rpnsa_pkg::req_item_t  req,
	input  rpnsa_pkg::dp_cmd_t    cmd,
	output rpnsa_pkg::dp_sts_t    sts,
	output rpnsa_pkg::rsp_item_t  rsp,
	output logic                  rsp_valid
);
	import rpnsa_pkg::*;

	req_item_t         req_q;
	logic [CountW-1:0] count_q;
	logic [63:0]       a_q, b_q, top_q;
	logic              sat_acc_q;
	logic [2:0]        status_q;
	logic              valid_q;
	logic [AddrW-1:0]  addr;
	logic              we;
	logic [63:0]       wdata, rdata;
	logic              alu_done, alu_sat;
	logic [63:0]       alu_res;
	logic [CountW-1:0] cm1, cm2;

	assign cm1 = count_q - CountW'(1);
	assign cm2 = count_q - CountW'(2);

	always_comb begin
		addr  = cm1[AddrW-1:0];
		we    = 1'b0;
		wdata = alu_res;
		if (cmd.wr_push) begin
			addr  = count_q[AddrW-1:0];
			we    = 1'b1;
			wdata = req_q.push_value;
		end else if (cmd.rd_b || cmd.wr_result) begin
			addr = cm2[AddrW-1:0];
			we   = cmd.wr_result;
		end
	end

	rpnsa_ram #(.Width(64), .Depth(StackDepth)) u_ram (
		.clk  (clk),
		.we   (we),
		.addr (addr),
		.wdata(wdata),
		.rdata(rdata)
	);

	// b arrives from the RAM in the same cycle the ALU starts
	rpnsa_alu u_alu (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.calc_start),
		.op    (req_q.op_code),
		.b_in  (cmd.cap_b ? rdata : b_q),
		.a_in  (a_q),
		.done  (alu_done),
		.result(alu_res),
		.sat   (alu_sat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			valid_q   <= 1'b0;
			sat_acc_q <= 1'b0;
			status_q  <= ST_OK;
		end else begin
			valid_q <= cmd.emit;
			if (cmd.load_req) begin
				sat_acc_q <= 1'b0;
				status_q  <= ST_OK;
			end
			if (cmd.wr_push) count_q <= count_q + CountW'(1);
			if (cmd.wr_result) begin
				count_q <= cm1;
				if (alu_sat) sat_acc_q <= 1'b1;
			end
			if (cmd.set_few)  status_q <= ST_FEW;
			if (cmd.set_full) status_q <= ST_FULL;
			if (cmd.set_divz) status_q <= ST_DIVZ;
			if (cmd.emit && status_q == ST_OK && sat_acc_q) status_q <= ST_SAT;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) req_q <= req;
		if (cmd.cap_a) a_q <= rdata;
		if (cmd.cap_b) b_q <= rdata;
		if (cmd.cap_top) top_q <= (count_q == '0) ? 64'd0 : rdata;
	end

	assign sts.is_oper   = req_q.req_type == REQ_OPER;
	assign sts.reduce    = req_q.reduce_all;
	assign sts.full      = count_q >= CountW'(StackDepth);
	assign sts.few       = count_q < CountW'(2);
	assign sts.empty     = count_q == '0;
	assign sts.divz      = (req_q.op_code == OP_DIV) && (a_q == 64'd0);
	assign sts.calc_done = alu_done;
	assign sts.more      = count_q > CountW'(1);

	assign rsp.top_value   = top_q;
	assign rsp.status      = (status_q == ST_OK && sat_acc_q) ? ST_SAT : status_q;
	assign rsp.depth_after = DepthW'(count_q);
	assign rsp_valid       = valid_q;
endmodule

>>> hw/rtl/rpnsa_ctrl.sv
// Controller state machine sequencing push, operate and reduce walks.
module rpnsa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output rpnsa_pkg::dp_cmd_t cmd,
	input  rpnsa_pkg::dp_sts_t sts
);
	import rpnsa_pkg::*;

	ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (start) state_d = S_PUSH;
			S_PUSH: begin
				if (!sts.is_oper || sts.few) state_d = S_RD_TOP;
				else state_d = S_RD_A;
			end
			S_RD_A:   state_d = S_RD_B;
			S_RD_B:   state_d = S_OPND;
			S_OPND:   state_d = sts.divz ? S_RD_TOP : S_CALC;
			S_CALC:   if (sts.calc_done) state_d = S_WR;
			S_WR:     state_d = sts.reduce ? S_PUSH : S_RD_TOP;
			S_RD_TOP: state_d = S_TOP;
			S_TOP:    state_d = S_DONE;
			S_DONE:   state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// S_PUSH decides the item; on a reduce walk it re-enters with is_oper set
	logic first_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) first_q <= 1'b0;
		else if (state_q == S_IDLE) first_q <= 1'b1;
		else if (state_q == S_PUSH) first_q <= 1'b0;
	end

	always_comb begin
		cmd  = '0;
		busy = state_q != S_IDLE;
		unique case (state_q)
			S_IDLE: cmd.load_req = start;
			S_PUSH: begin
				if (!sts.is_oper) begin
					if (sts.full) cmd.set_full = 1'b1;
					else cmd.wr_push = 1'b1;
				end else if (sts.few && first_q) begin
					cmd.set_few = 1'b1;
				end
			end
			S_RD_A:   cmd.rd_a = 1'b1;
			S_RD_B: begin
				cmd.rd_b  = 1'b1;
				cmd.cap_a = 1'b1;
			end
			S_OPND: begin
				cmd.cap_b = 1'b1;
				if (sts.divz) cmd.set_divz = 1'b1;
				else cmd.calc_start = 1'b1;
			end
			S_WR:     cmd.wr_result = 1'b1;
			S_RD_TOP: cmd.rd_top = 1'b1;
			S_TOP:    cmd.cap_top = 1'b1;
			S_DONE:   cmd.emit = 1'b1;
			default: ;
		endcase
	end
endmodule

>>> hw/rtl/rpnsa_checker.sv
// Port-level checker for the RPN stack arithmetic unit, bound to the top level.
module rpnsa_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic                 done,
	input rpnsa_pkg::rsp_item_t result
);
	import rpnsa_pkg::*;

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("no busy after transfer");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done && !start |=> !busy) else $error("busy after result");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.status <= ST_SAT) else $error("bad status");
	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.depth_after <= 7'(StackDepth)) else $error("bad depth");
endmodule

bind rpn_stack_arithmetic_unit rpnsa_checker u_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.result(result)
);
